/* rtl/ptts_pkg.sv */
package ptts_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int HANDLER_W      = 8;
    localparam int TIME_W         = 16;
    localparam int SLOT_W         = 3;
    localparam int FUNC_W         = 3;
    localparam int KIND_W         = 2;
    localparam int FIRE_CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int S_TDATA_W      = 48;
    localparam int M_TDATA_W      = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK    = 3'd0,
        FUNC_CREATE  = 3'd1,
        FUNC_SUSPEND = 3'd2,
        FUNC_RESUME  = 3'd3,
        FUNC_DELETE  = 3'd4
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRE = 2'd0,
        KIND_IDLE = 2'd1,
        KIND_ACK  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic                 create;
        logic                 suspend;
        logic                 resume;
        logic                 del;
        logic [HANDLER_W-1:0] handler;
        logic [TIME_W-1:0]    period;
        logic [TIME_W-1:0]    first_delay;
    } ctl_t;

    typedef struct packed {
        logic                 tok;
        logic                 fire;
        logic [HANDLER_W-1:0] handler;
    } cell_stat_t;

endpackage

/* rtl/ptts_cell.sv */
module ptts_cell
    import ptts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctl_t       ctl,
    input  logic       sel,
    input  logic       tok_in,
    input  logic       load,
    input  logic       step,
    output cell_stat_t stat
);

    logic [HANDLER_W-1:0] hnd_reg, hnd_next;
    logic                 run_reg, run_next;
    logic [TIME_W-1:0]    per_reg, per_next;
    logic [TIME_W-1:0]    cd_reg,  cd_next;
    logic                 tok_reg, tok_next;

    always_comb
    begin
        hnd_next = hnd_reg;
        run_next = run_reg;
        per_next = per_reg;
        cd_next  = cd_reg;
        tok_next = load ? tok_in : tok_reg;
        if (sel)
        begin
            priority if (ctl.create)
            begin
                if (ctl.handler != '0 && hnd_reg == '0)
                begin
                    hnd_next = ctl.handler;
                    per_next = ctl.period;
                    run_next = 1'b1;
                    cd_next  = ctl.first_delay;
                end
            end
            else if (ctl.suspend)
            begin
                run_next = 1'b0;
            end
            else if (ctl.resume)
            begin
                run_next = 1'b1;
            end
            else if (ctl.del)
            begin
                hnd_next = '0;
            end
            else
            begin
                run_next = run_reg;
            end
        end
        if (tok_reg && step && run_reg)
        begin
            cd_next = (cd_reg == '0) ? per_reg - TIME_W'(1) : cd_reg - TIME_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hnd_reg <= '0;
            run_reg <= 1'b0;
            per_reg <= '0;
            cd_reg  <= '0;
            tok_reg <= 1'b0;
        end
        else
        begin
            hnd_reg <= hnd_next;
            run_reg <= run_next;
            per_reg <= per_next;
            cd_reg  <= cd_next;
            tok_reg <= tok_next;
        end
    end

    assign stat.tok     = tok_reg;
    assign stat.fire    = tok_reg && run_reg && cd_reg == '0 && hnd_reg != '0;
    assign stat.handler = stat.fire ? hnd_reg : '0;

endmodule

/* rtl/periodic_task_tick_scheduler.sv */
// Channel  Dir  tuser            tdata                                          tlast
// s_axis   in   func[2:0]        slot[2:0] handler[10:3] period[26:11]          -
//                                first_delay[42:27], zero pad to 48
// m_axis   out  kind[1:0]        task_slot[2:0] task_handler[10:3]              last
//                                status[11], zero pad to 16
//
// A command gives its acknowledge in the output register.
// A tick walks a token down the row of slot cells, one cell a cycle while the
// walk is not stalled, then ends in the flush state with the final result.
// A fire waits in a pending register so the final result can carry last; a
// second fire stalls the walk until the output register frees up.
// Reset clears every slot; no input transaction is taken outside the idle state.
module periodic_task_tick_scheduler
    import ptts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // slot, handler, period, first_delay
    input  logic [FUNC_W-1:0]    s_tuser,  // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // task_slot, task_handler, status
    output logic [KIND_W-1:0]    m_tuser,  // kind
    output logic                 m_tlast
);

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    logic [SLOT_W-1:0]    in_slot;
    logic [HANDLER_W-1:0] in_handler;
    logic [TIME_W-1:0]    in_period;
    logic [TIME_W-1:0]    in_first_delay;

    assign in_slot        = s_tdata[2:0];
    assign in_handler     = s_tdata[10:3];
    assign in_period      = s_tdata[26:11];
    assign in_first_delay = s_tdata[42:27];

    state_t state_reg, state_next;

    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg, out_kind_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic [HANDLER_W-1:0]  out_hnd_reg, out_hnd_next;
    logic                  out_status_reg, out_status_next;
    logic                  out_last_reg, out_last_next;

    logic                  pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]     pend_slot_reg, pend_slot_next;
    logic [HANDLER_W-1:0]  pend_hnd_reg, pend_hnd_next;

    logic [FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;

    logic                  accept;
    logic                  is_tick;
    logic                  cmd_acc;
    logic                  start;
    logic                  advance;
    logic                  out_free;
    logic                  any_fire;
    logic                  fire_report;
    logic                  scan_done;
    logic [HANDLER_W-1:0]  fire_hnd;
    logic [TASK_SLOTS-1:0] tok_vec;

    ctl_t                  ctl;
    logic [TASK_SLOTS-1:0] sel;
    cell_stat_t            stat [TASK_SLOTS];

    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_tick  = (s_tuser == FUNC_TICK);
    assign cmd_acc  = accept && !is_tick;

    always_comb
    begin
        any_fire = 1'b0;
        fire_hnd = '0;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            any_fire   = any_fire | stat[i].fire;
            fire_hnd   = fire_hnd | stat[i].handler;
            tok_vec[i] = stat[i].tok;
        end
    end

    assign fire_report = any_fire && (fire_cnt_reg < FIRE_CNT_W'(MAX_RESULTS));
    assign scan_done   = tok_vec[TASK_SLOTS-1];

    always_comb
    begin
        s_tready = 1'b0;
        start    = 1'b0;
        advance  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = out_free;
                start    = accept && is_tick;
            end
            ST_SCAN:
            begin
                advance = !fire_report || !pend_valid_reg || out_free;
            end
            ST_FLUSH:
            begin
                advance = 1'b0;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (advance && scan_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_hnd_next    = out_hnd_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_hnd_next   = pend_hnd_reg;
        fire_cnt_next   = fire_cnt_reg;
        idx_next        = idx_reg;

        if (cmd_acc)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_ACK;
            out_slot_next   = in_slot;
            out_hnd_next    = '0;
            out_status_next = (s_tuser == FUNC_CREATE) && (in_handler == '0);
            out_last_next   = 1'b1;
        end

        if (start)
        begin
            fire_cnt_next   = '0;
            idx_next        = '0;
            pend_valid_next = 1'b0;
        end

        if (advance)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (fire_report)
            begin
                fire_cnt_next   = fire_cnt_reg + FIRE_CNT_W'(1);
                pend_valid_next = 1'b1;
                pend_slot_next  = SLOT_W'(idx_reg);
                pend_hnd_next   = fire_hnd;
                if (pend_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_FIRE;
                    out_slot_next   = pend_slot_reg;
                    out_hnd_next    = pend_hnd_reg;
                    out_status_next = 1'b0;
                    out_last_next   = 1'b0;
                end
            end
        end

        if (state_reg == ST_FLUSH && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = 1'b0;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                out_kind_next = KIND_FIRE;
                out_slot_next = pend_slot_reg;
                out_hnd_next  = pend_hnd_reg;
            end
            else
            begin
                out_kind_next = KIND_IDLE;
                out_slot_next = '0;
                out_hnd_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            fire_cnt_reg   <= '0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            fire_cnt_reg   <= fire_cnt_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg   <= out_kind_next;
        out_slot_reg   <= out_slot_next;
        out_hnd_reg    <= out_hnd_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        pend_slot_reg  <= pend_slot_next;
        pend_hnd_reg   <= pend_hnd_next;
    end

    assign ctl.create      = cmd_acc && (s_tuser == FUNC_CREATE);
    assign ctl.suspend     = cmd_acc && (s_tuser == FUNC_SUSPEND);
    assign ctl.resume      = cmd_acc && (s_tuser == FUNC_RESUME);
    assign ctl.del         = cmd_acc && (s_tuser == FUNC_DELETE);
    assign ctl.handler     = in_handler;
    assign ctl.period      = in_period;
    assign ctl.first_delay = in_first_delay;

    for (genvar i = 0; i < TASK_SLOTS; i++)
    begin : g_cell
        logic tok_prev;

        assign sel[i] = cmd_acc && (int'(in_slot) == i);

        if (i == 0)
        begin : g_head
            assign tok_prev = start;
        end
        else
        begin : g_body
            assign tok_prev = stat[i-1].tok;
        end

        ptts_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .sel    (sel[i]),
            .tok_in (tok_prev),
            .load   (advance || start),
            .step   (advance),
            .stat   (stat[i])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - SLOT_W - HANDLER_W - 1){1'b0}},
                       out_status_reg, out_hnd_reg, out_slot_reg};

    a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one slot cell holds the scan token");

    a_tok_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> $onehot(tok_vec))
        else $error("scan running without a token");

    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending fire left over after a tick");

    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= FIRE_CNT_W'(MAX_RESULTS))
        else $error("fire count above the report limit");

    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && out_free) |=> (m_tvalid && m_tlast))
        else $error("tick ended without a final result");

endmodule

/* tb/periodic_task_tick_scheduler_tb.sv */
module periodic_task_tick_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptts_pkg::*;

    localparam int SLOTS       = TASK_SLOTS_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 3000;
    localparam int TAIL_CYCLES = 4 * (SLOTS + 2);

    typedef struct packed {
        kind_t                kind;
        logic [SLOT_W-1:0]    task_slot;
        logic [HANDLER_W-1:0] task_handler;
        logic                 status;
        logic                 last;
    } sched_event_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // slot, handler, period, first_delay
    logic [FUNC_W-1:0]    s_tuser;   // func
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // task_slot, task_handler, status
    logic [KIND_W-1:0]    m_tuser;   // kind
    logic                 m_tlast;

    logic [HANDLER_W-1:0] tbl_handler   [SLOTS];
    logic                 tbl_running   [SLOTS];
    logic [TIME_W-1:0]    tbl_period    [SLOTS];
    logic [TIME_W-1:0]    tbl_countdown [SLOTS];

    sched_event_t sched_events_due [$];
    int           fail_count = 0;
    int           burst_left = 0;
    bit           hold_req   = 1'b0;

    periodic_task_tick_scheduler #(
        .TASK_SLOTS (SLOTS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void schedule_command(
        input logic [FUNC_W-1:0]    func,
        input logic [SLOT_W-1:0]    slot,
        input logic [HANDLER_W-1:0] handler,
        input logic [TIME_W-1:0]    period,
        input logic [TIME_W-1:0]    first_delay
    );
        sched_event_t batch [$];
        sched_event_t ev;
        int           fired;
        logic         status;
        fired  = 0;
        status = 1'b0;
        if (func == FUNC_TICK)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (tbl_running[i])
                begin
                    if (tbl_countdown[i] == '0)
                    begin
                        if (tbl_handler[i] != '0 && fired < MAX_RESULTS)
                        begin
                            ev = '{kind: KIND_FIRE, task_slot: SLOT_W'(i),
                                   task_handler: tbl_handler[i], status: 1'b0, last: 1'b0};
                            batch.push_back(ev);
                            fired++;
                        end
                        tbl_countdown[i] = tbl_period[i] - 1'b1;
                    end
                    else
                    begin
                        tbl_countdown[i] = tbl_countdown[i] - 1'b1;
                    end
                end
            end
            if (fired == 0)
            begin
                ev = '{kind: KIND_IDLE, task_slot: '0, task_handler: '0,
                       status: 1'b0, last: 1'b0};
                batch.push_back(ev);
            end
        end
        else
        begin
            case (func)
                FUNC_CREATE:
                begin
                    if (handler == '0)
                    begin
                        status = 1'b1;
                    end
                    else if (tbl_handler[slot] == '0)
                    begin
                        tbl_handler[slot]   = handler;
                        tbl_period[slot]    = period;
                        tbl_running[slot]   = 1'b1;
                        tbl_countdown[slot] = first_delay;
                    end
                end
                FUNC_SUSPEND: tbl_running[slot] = 1'b0;
                FUNC_RESUME:  tbl_running[slot] = 1'b1;
                FUNC_DELETE:  tbl_handler[slot] = '0;
                default:      ;
            endcase
            ev = '{kind: KIND_ACK, task_slot: slot, task_handler: '0,
                   status: status, last: 1'b0};
            batch.push_back(ev);
        end
        ev      = batch.pop_back();
        ev.last = 1'b1;
        batch.push_back(ev);
        foreach (batch[k])
            sched_events_due.push_back(batch[k]);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t mismatch %s: expected %0h actual %0h",
                     $time, name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        sched_event_t got;
        sched_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind         = kind_t'(m_tuser);
            got.task_slot    = m_tdata[2:0];
            got.task_handler = m_tdata[10:3];
            got.status       = m_tdata[11];
            got.last         = m_tlast;
            if (sched_events_due.size() == 0)
            begin
                $display({"%0t unexpected result: expected none actual kind %0d slot %0d",
                          " handler %0h status %0d last %0d"},
                         $time, got.kind, got.task_slot, got.task_handler, got.status,
                         got.last);
                fail_count++;
            end
            else
            begin
                want = sched_events_due.pop_front();
                check_field("kind", 16'(want.kind), 16'(got.kind));
                check_field("task_slot", 16'(want.task_slot), 16'(got.task_slot));
                check_field("task_handler", 16'(want.task_handler), 16'(got.task_handler));
                check_field("status", 16'(want.status), 16'(got.status));
                check_field("last", 16'(want.last), 16'(got.last));
            end
        end
    end

    initial
    begin : result_sink
        int hold_left;
        int rx_left;
        bit rx_on;
        hold_left = 0;
        rx_left   = 0;
        rx_on     = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_on = !rx_on;
                    if (rx_on)
                        rx_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 10);
                    else
                        rx_left = $urandom_range(1, 6);
                end
                rx_left--;
                m_tready <= rx_on;
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_cmd(
        input logic [FUNC_W-1:0]    func,
        input logic [SLOT_W-1:0]    slot,
        input logic [HANDLER_W-1:0] handler,
        input logic [TIME_W-1:0]    period,
        input logic [TIME_W-1:0]    first_delay
    );
        int unsigned gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= S_TDATA_W'({first_delay, period, handler, slot});
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        schedule_command(func, slot, handler, period, first_delay);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sched_events_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_empty_table();
        send_cmd(FUNC_TICK, 3'd0, 8'h00, 16'h0000, 16'h0000);
        send_cmd(FUNC_CREATE, 3'd2, 8'h00, 16'h0005, 16'h0001);
        send_cmd(FUNC_SUSPEND, 3'd5, 8'h00, 16'h0000, 16'h0000);
        send_cmd(FUNC_RESUME, 3'd6, 8'h00, 16'h0000, 16'h0000);
        send_cmd(FUNC_DELETE, 3'd4, 8'h00, 16'h0000, 16'h0000);
        // spare codes must only acknowledge
        for (int c = int'(FUNC_DELETE) + 1; c < (1 << FUNC_W); c++)
            send_cmd(FUNC_W'(c), SLOT_W'(c), 8'h5A, 16'h0001, 16'h0000);
    endtask

    task automatic test_create_and_fire();
        send_cmd(FUNC_CREATE, 3'd0, 8'hFF, 16'h0001, 16'h0000);
        send_cmd(FUNC_CREATE, 3'd0, 8'h11, 16'h0009, 16'h0009);
        send_cmd(FUNC_CREATE, 3'd7, 8'h01, 16'h0000, 16'h0000);
        send_cmd(FUNC_CREATE, 3'd3, 8'h80, 16'hFFFF, 16'hFFFF);
        send_cmd(FUNC_TICK, 3'd0, 8'h00, 16'h0000, 16'h0000);
        send_cmd(FUNC_TICK, 3'd0, 8'h00, 16'h0000, 16'h0000);
        send_cmd(FUNC_DELETE, 3'd0, 8'h00, 16'h0000, 16'h0000);
        send_cmd(FUNC_TICK, 3'd7, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_cmd(FUNC_SUSPEND, 3'd7, 8'h00, 16'h0000, 16'h0000);
        send_cmd(FUNC_RESUME, 3'd7, 8'h00, 16'h0000, 16'h0000);
        send_cmd(FUNC_CREATE, 3'd0, 8'h22, 16'h0002, 16'h0001);
    endtask

    task automatic test_full_table();
        for (int s = 0; s < SLOTS; s++)
        begin
            send_cmd(FUNC_DELETE, SLOT_W'(s), 8'h00, 16'h0000, 16'h0000);
            send_cmd(FUNC_CREATE, SLOT_W'(s), HANDLER_W'($urandom_range(1, 255)), 16'h0001,
                     16'h0000);
        end
        repeat (4) send_cmd(FUNC_TICK, 3'd0, 8'h00, 16'h0000, 16'h0000);
    endtask

    task automatic test_backpressure();
        // stall the output long enough for the block to back up its input
        hold_req = 1'b1;
        repeat (12) send_cmd(FUNC_TICK, 3'd0, 8'h00, 16'h0000, 16'h0000);
        drain_results();
    endtask

    task automatic test_random_traffic(input int count);
        int unsigned          r;
        logic [SLOT_W-1:0]    slot;
        logic [HANDLER_W-1:0] handler;
        logic [TIME_W-1:0]    period;
        logic [TIME_W-1:0]    first_delay;
        for (int n = 0; n < count; n++)
        begin
            r           = $urandom_range(0, 99);
            slot        = SLOT_W'($urandom_range(0, SLOTS - 1));
            handler     = ($urandom_range(0, 9) == 0) ? '0 : HANDLER_W'($urandom_range(1, 255));
            period      = ($urandom_range(0, 3) != 0) ? TIME_W'($urandom_range(0, 4))
                                                      : TIME_W'($urandom);
            first_delay = ($urandom_range(0, 3) != 0) ? TIME_W'($urandom_range(0, 3))
                                                      : TIME_W'($urandom);
            if (r < 45)
            begin
                send_cmd(FUNC_TICK, slot, handler, period, first_delay);
            end
            else if (r < 65)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_cmd(FUNC_DELETE, slot, handler, period, first_delay);
                send_cmd(FUNC_CREATE, slot, handler, period, first_delay);
            end
            else if (r < 75)
            begin
                send_cmd(FUNC_SUSPEND, slot, handler, period, first_delay);
            end
            else if (r < 85)
            begin
                send_cmd(FUNC_RESUME, slot, handler, period, first_delay);
            end
            else if (r < 95)
            begin
                send_cmd(FUNC_DELETE, slot, handler, period, first_delay);
            end
            else
            begin
                repeat ($urandom_range(3, 6))
                    send_cmd(FUNC_TICK, slot, handler, period, first_delay);
            end
            if (n % 80 == 79)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_handler[i]   = '0;
            tbl_running[i]   = 1'b0;
            tbl_period[i]    = '0;
            tbl_countdown[i] = '0;
        end
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_create_and_fire();
        test_full_table();
        test_backpressure();
        test_random_traffic(260);

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
